// File: design/spanning_tree_weight_product_defines.svh
// assertion macros used by the top rtl file
`ifndef SPANNING_TREE_WEIGHT_PRODUCT_DEFINES_SVH
`define SPANNING_TREE_WEIGHT_PRODUCT_DEFINES_SVH

// same-cycle implication, checked on clk, quiet in reset
`define STWP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on clk, quiet in reset
`define STWP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/stwp_pkg.sv
`default_nettype none

package stwp_pkg;

  localparam int NODES    = 1024;
  localparam int NODE_W   = 10;
  localparam int SIZE_W   = 11;
  localparam int PROD_W   = 30;
  localparam int WEIGHT_W = 32;

  typedef logic [NODE_W-1:0]   node_t;
  typedef logic [SIZE_W-1:0]   size_t;
  typedef logic [PROD_W-1:0]   prod_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  localparam weight_t MODP     = 32'd1000000007;
  localparam weight_t MODP_X2  = 32'd2000000014;
  localparam node_t   NODE_LAST = node_t'(NODES - 1);
  localparam size_t   SIZE_ONE  = size_t'(1);
  localparam prod_t   PROD_ONE  = prod_t'(1);

endpackage

`default_nettype wire

// File: design/stwp_modmul.sv
`default_nettype none

module stwp_modmul
  import stwp_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     start,
  input  prod_t   base,
  input  weight_t weight,
  output logic    done,
  output prod_t   result
);

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_RED  = 2'd1;
  localparam logic [1:0] M_MUL  = 2'd2;
  localparam logic [1:0] M_DONE = 2'd3;
  localparam logic [4:0] MUL_TOP = 5'(PROD_W - 1);

  logic [1:0] state;
  logic [4:0] bit_idx;
  prod_t      x;
  prod_t      acc;
  weight_t    w;
  weight_t    t;
  weight_t    t_red;

  // double and add one bit of the reduced weight, then fold back below the prime
  always_comb begin
    t = {1'b0, acc, 1'b0} + (w[bit_idx] ? {2'b00, x} : '0);
    if (t >= MODP_X2) begin
      t_red = t - MODP_X2;
    end else if (t >= MODP) begin
      t_red = t - MODP;
    end else begin
      t_red = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= M_IDLE;
      bit_idx <= MUL_TOP;
    end else begin
      case (state)
        M_IDLE, M_DONE: begin
          if (start) begin
            x     <= base;
            w     <= weight;
            state <= M_RED;
          end
        end
        M_RED: begin
          // at most four subtractions for a 32 bit weight
          if (w >= MODP) begin
            w <= w - MODP;
          end else begin
            acc     <= '0;
            bit_idx <= MUL_TOP;
            state   <= M_MUL;
          end
        end
        M_MUL: begin
          acc     <= t_red[PROD_W-1:0];
          bit_idx <= bit_idx - 5'd1;
          if (bit_idx == 5'd0) begin
            state <= M_DONE;
          end
        end
        default: state <= M_IDLE;
      endcase
    end
  end

  assign done   = (state == M_DONE);
  assign result = acc;

endmodule

`default_nettype wire

// File: design/spanning_tree_weight_product.sv
// union-find edge engine, one edge beat in, one result beat out; done is a one-cycle strobe
// done waits for the bit-serial modular multiplier started at accept (weight reduction,
//   then one multiply step per bit of the reduced weight) and for the two find walks
//   (one parent hop at a time, each hop rewritten once), whichever ends later
// one edge at a time; a new start is taken in the cycle done is high
// reset and restart add a clearing pass over all 1024 entries of both memories, busy high
`default_nettype none
`include "spanning_tree_weight_product_defines.svh"

module spanning_tree_weight_product
  import stwp_pkg::*;
(
  input  wire     clk,
  input  wire     rst,
  input  wire     start,
  output logic    busy,
  input  node_t   node_a,
  input  node_t   node_b,
  input  weight_t weight,
  input  wire     restart,
  output logic    done,
  output logic    merged,
  output prod_t   product,
  output size_t   tree_size
);

  // sequencer codes
  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_W1_RD  = 4'd2;
  localparam logic [3:0] S_W1_CHK = 4'd3;
  localparam logic [3:0] S_W2_CHK = 4'd4;
  localparam logic [3:0] S_SZA    = 4'd5;
  localparam logic [3:0] S_SZB    = 4'd6;
  localparam logic [3:0] S_MERGE  = 4'd7;
  localparam logic [3:0] S_FIXA   = 4'd8;
  localparam logic [3:0] S_WAIT   = 4'd9;

  logic [3:0] state;
  node_t      clr_idx;
  logic       item_pending;   // a restart beat waits behind the clearing pass
  logic       which;          // 0 while resolving node_a, 1 for node_b
  node_t      a_reg;
  node_t      b_reg;
  node_t      root;
  node_t      cur;
  node_t      ra;
  node_t      rb;
  node_t      big_r;
  size_t      sa;
  prod_t      product_reg;

  // parent memory, one read and one write port
  node_t      parent_mem [NODES];
  node_t      pdat;
  node_t      pr_addr;
  logic       pw_en;
  node_t      pw_addr;
  node_t      pw_data;

  // size memory, meaningful at roots only
  size_t      size_mem [NODES];
  size_t      sdat;
  node_t      sr_addr;
  logic       sw_en;
  node_t      sw_addr;
  size_t      sw_data;

  // modular multiplier, started speculatively at accept
  logic       mm_start;
  prod_t      mm_base;
  logic       mm_done;
  prod_t      mm_result;

  node_t      walk_node;
  logic       ra_small;
  node_t      big;
  node_t      lesser;
  size_t      size_sum;

  assign busy      = (state != S_IDLE);
  assign walk_node = which ? b_reg : a_reg;
  assign product   = product_reg;

  // merge decision, valid in S_MERGE where sdat holds size of rb
  assign ra_small = (sa < sdat);
  assign big      = ra_small ? rb : ra;
  assign lesser   = ra_small ? ra : rb;
  assign size_sum = sa + sdat;

  assign mm_start = start && !busy;
  assign mm_base  = restart ? PROD_ONE : product_reg;

  stwp_modmul u_modmul (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .base   (mm_base),
    .weight (weight),
    .done   (mm_done),
    .result (mm_result)
  );

  // memory address and write selection
  always_comb begin
    pr_addr = root;
    pw_en   = 1'b0;
    pw_addr = cur;
    pw_data = root;
    sw_en   = 1'b0;
    sw_addr = big;
    sw_data = size_sum;
    sr_addr = (state == S_SZB) ? rb : ra;
    case (state)
      S_CLEAR: begin
        pw_en   = 1'b1;
        pw_addr = clr_idx;
        pw_data = clr_idx;
        sw_en   = 1'b1;
        sw_addr = clr_idx;
        sw_data = SIZE_ONE;
      end
      S_W1_CHK: begin
        // keep climbing, or start the compression walk at the walk node
        pr_addr = (pdat != root) ? pdat : walk_node;
      end
      S_W2_CHK: begin
        // point the visited node straight at the root, read the entry of its old parent
        pr_addr = pdat;
        pw_en   = 1'b1;
        pw_addr = cur;
        pw_data = root;
      end
      S_MERGE: begin
        if (ra != rb) begin
          pw_en   = 1'b1;
          pw_addr = lesser;
          pw_data = big;
          sw_en   = 1'b1;
        end
      end
      S_FIXA: begin
        // final find on node_a compresses it onto the new root
        pw_en   = 1'b1;
        pw_addr = a_reg;
        pw_data = big_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pw_en) begin
      parent_mem[pw_addr] <= pw_data;
    end
    pdat <= parent_mem[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      size_mem[sw_addr] <= sw_data;
    end
    sdat <= size_mem[sr_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      item_pending <= 1'b0;
      which        <= 1'b0;
      product_reg  <= PROD_ONE;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + node_t'(1);
          if (clr_idx == NODE_LAST) begin
            clr_idx <= '0;
            state   <= item_pending ? S_W1_RD : S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            a_reg <= node_a;
            b_reg <= node_b;
            root  <= node_a;
            which <= 1'b0;
            if (restart) begin
              product_reg  <= PROD_ONE;
              item_pending <= 1'b1;
              state        <= S_CLEAR;
            end else begin
              state <= S_W1_RD;
            end
          end
        end
        S_W1_RD: begin
          state <= S_W1_CHK;
        end
        S_W1_CHK: begin
          if (pdat != root) begin
            root <= pdat;
          end else if (walk_node != root) begin
            cur   <= walk_node;
            state <= S_W2_CHK;
          end else if (!which) begin
            ra    <= root;
            which <= 1'b1;
            root  <= b_reg;
            state <= S_W1_RD;
          end else begin
            rb    <= root;
            state <= S_SZA;
          end
        end
        S_W2_CHK: begin
          cur <= pdat;
          if (pdat == root) begin
            if (!which) begin
              ra    <= root;
              which <= 1'b1;
              root  <= b_reg;
              state <= S_W1_RD;
            end else begin
              rb    <= root;
              state <= S_SZA;
            end
          end
        end
        S_SZA: begin
          state <= S_SZB;
        end
        S_SZB: begin
          sa    <= sdat;
          state <= S_MERGE;
        end
        S_MERGE: begin
          big_r <= big;
          if (ra == rb) begin
            merged    <= 1'b0;
            tree_size <= sa;
            state     <= S_WAIT;
          end else begin
            merged    <= 1'b1;
            tree_size <= size_sum;
            state     <= (ra_small && (a_reg != ra)) ? S_FIXA : S_WAIT;
          end
        end
        S_FIXA: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (mm_done) begin
            if (merged) begin
              product_reg <= mm_result;
            end
            item_pending <= 1'b0;
            done         <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `STWP_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `STWP_ASSERT_IMP(a_done_idle, done, state == S_IDLE, "result strobe outside idle")
  `STWP_ASSERT_IMP(a_merge_size, done && merged, tree_size > SIZE_ONE, "merged tree of size one")
  `STWP_ASSERT_IMP(a_write_busy, pw_en || sw_en, busy, "memory write while idle")

endmodule

`default_nettype wire
